// ===== src/alls_pkg.sv =====
package alls_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic             success;
        logic             full_reject;
        logic [CNT_W-1:0] count;
    } t_out_word;

    // query token walking down the cell row
    typedef struct packed {
        logic                    valid;
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] value;
        logic                    hit;
        logic                    done;
    } t_token;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
    } t_entry;

endpackage

// ===== src/array_linked_list_set_top.sv =====
// Set of distinct 32-bit values held in a row of CAPACITY storage cells.
// Command channel: a word (command, value) is taken at a clock edge where
// start is high and busy is low. Commands: add, remove, search; code 3 is
// a no-op that still returns a result.
// Result channel: o_strobe is high for exactly one cycle with o_word
// (success, full_reject, count). The receiver cannot hold results off.
// Timing: the query token moves one cell per cycle through the cell row,
// and o_strobe and o_word are registered as it leaves the last cell; the
// result is taken at the next edge. busy falls in the strobe cycle, so
// a new command can be taken at that same edge, but not before: a command
// is taken only once the last one is through, set by the walk through the cell row.
// Cells stay packed from cell 0: add writes the first empty cell, remove
// shifts the cells behind the removed entry one place toward cell 0.
// An add of a new value into a full set returns success 0 and full_reject 1.
// Reset (synchronous, active low) empties the set and drops any command
// in flight; no clearing pass is needed.
module array_linked_list_set_top
    import alls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_strobe,
    output t_out_word o_word
);

    t_token w_tok   [0:CAPACITY];
    logic   w_pull  [0:CAPACITY];
    t_entry w_entry [0:CAPACITY];

    logic             r_busy;
    logic             r_strobe;
    t_out_word        r_word;
    logic [CNT_W-1:0] r_count;

    t_token           last;
    t_out_word        n_word;
    logic [CNT_W-1:0] n_count;
    logic             accept;

    assign accept = start && !r_busy;

    assign w_tok[0] = '{valid:   accept,
                        command: i_word.command,
                        value:   i_word.value,
                        hit:     1'b0,
                        done:    1'b0};

    assign w_pull[CAPACITY]  = 1'b0;
    assign w_entry[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        alls_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_pull  (w_pull[g+1]),
            .i_right (w_entry[g+1]),
            .o_pull  (w_pull[g]),
            .o_entry (w_entry[g])
        );
    end

    assign last = w_tok[CAPACITY];

    always_comb begin
        n_count            = r_count;
        n_word.success     = 1'b0;
        n_word.full_reject = 1'b0;
        unique case (last.command)
            CMD_ADD: begin
                n_word.success     = last.done;
                n_word.full_reject = !last.hit && !last.done;
                if (last.done) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                n_word.success = last.hit;
                if (last.hit) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_SEARCH: begin
                n_word.success = last.hit;
            end
            default: begin
            end
        endcase
        n_word.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_strobe <= last.valid;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (last.valid) begin
                r_busy <= 1'b0;
            end
            if (last.valid) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (last.valid) begin
            r_word <= n_word;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_word   = r_word;

endmodule

// ===== src/alls_cell.sv =====
module alls_cell
    import alls_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    output t_token o_tok,
    input  logic   i_pull,
    input  t_entry i_right,
    output logic   o_pull,
    output t_entry o_entry
);

    t_token                  r_tok;
    logic                    r_valid;
    logic signed [VAL_W-1:0] r_value;

    t_token                  n_tok;
    logic                    n_valid;
    logic signed [VAL_W-1:0] n_value;
    logic                    hit_here;

    assign hit_here = r_valid && (r_value == r_tok.value);

    always_comb begin
        n_tok   = r_tok;
        n_valid = r_valid;
        n_value = r_value;
        o_pull  = 1'b0;
        if (r_tok.valid) begin
            unique case (r_tok.command)
                CMD_ADD: begin
                    if (hit_here) begin
                        n_tok.hit = 1'b1;
                    end else if (!r_valid && !r_tok.hit && !r_tok.done) begin
                        n_valid    = 1'b1;
                        n_value    = r_tok.value;
                        n_tok.done = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (r_tok.hit) begin
                        // compact: hand contents to the left neighbor
                        o_pull  = 1'b1;
                        n_valid = 1'b0;
                    end else if (hit_here) begin
                        n_valid   = 1'b0;
                        n_tok.hit = 1'b1;
                    end
                end
                CMD_SEARCH: begin
                    if (hit_here) begin
                        n_tok.hit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_pull) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    assign o_tok         = n_tok;
    assign o_entry.valid = r_valid;
    assign o_entry.value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_tok   <= i_tok;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== tb/sv/alls_checker.sv =====
module alls_checker
    import alls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_word  i_cmd_word,
    input  logic      i_strobe,
    input  t_out_word i_result_word,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results,
    output int        o_full_rejects
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINK_W = CNT_W;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

    // shadow of the node store, links and free list
    logic [VAL_W-1:0]  node_value [CAPACITY];
    logic [LINK_W-1:0] next_link  [CAPACITY];
    logic [LINK_W-1:0] prev_link  [CAPACITY];
    logic [LINK_W-1:0] list_head;
    logic [LINK_W-1:0] list_tail;
    logic [LINK_W-1:0] free_head;
    logic [CNT_W-1:0]  set_size;

    t_out_word outcome_queue [$];

    function automatic logic [LINK_W-1:0] locate_node(logic [VAL_W-1:0] v);
        logic [LINK_W-1:0] cur;
        cur = list_head;
        for (int s = 0; s < CAPACITY; s++) begin
            if (cur >= CAPACITY) return NIL;
            if (node_value[cur] == v) return cur;
            cur = next_link[cur];
        end
        return NIL;
    endfunction

    function automatic t_out_word apply_set_op(t_in_word w);
        t_out_word         r;
        logic [LINK_W-1:0] n;
        logic [LINK_W-1:0] nx;
        logic [LINK_W-1:0] pv;
        r = '0;
        case (w.command)
            CMD_ADD: begin
                if (locate_node(w.value) == NIL) begin
                    if (free_head >= CAPACITY) begin
                        r.full_reject = 1'b1;
                    end else begin
                        n = free_head;
                        free_head = next_link[n];
                        if (free_head < CAPACITY) prev_link[free_head] = NIL;
                        node_value[n] = w.value;
                        next_link[n] = NIL;
                        prev_link[n] = list_tail;
                        if (list_tail < CAPACITY) next_link[list_tail] = n;
                        else list_head = n;
                        list_tail = n;
                        set_size = set_size + 1'b1;
                        r.success = 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                n = locate_node(w.value);
                if (n < CAPACITY) begin
                    nx = next_link[n];
                    pv = prev_link[n];
                    if (pv < CAPACITY) next_link[pv] = nx;
                    else list_head = nx;
                    if (nx < CAPACITY) prev_link[nx] = pv;
                    else list_tail = pv;
                    next_link[n] = free_head;
                    prev_link[n] = NIL;
                    if (free_head < CAPACITY) prev_link[free_head] = n;
                    free_head = n;
                    if (set_size > 0) set_size = set_size - 1'b1;
                    r.success = 1'b1;
                end
            end
            CMD_SEARCH: begin
                r.success = (locate_node(w.value) != NIL);
            end
            default: begin
            end
        endcase
        r.count = set_size;
        return r;
    endfunction

    task automatic flag_failure(string what, t_out_word want, t_out_word got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("[%0t] %s: expected success=%0b full_reject=%0b count=%0d,",
                     $time, what, want.success, want.full_reject, want.count,
                     " got success=%0b full_reject=%0b count=%0d",
                     got.success, got.full_reject, got.count);
    endtask

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results      = 0;
        o_full_rejects = 0;
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                node_value[i] = '0;
                next_link[i]  = LINK_W'(i + 1);
                prev_link[i]  = (i == 0) ? NIL : LINK_W'(i - 1);
            end
            list_head = NIL;
            list_tail = NIL;
            free_head = '0;
            set_size  = '0;
            outcome_queue.delete();
        end else begin
            if (i_strobe) begin
                o_results++;
                if (i_result_word.full_reject === 1'b1) o_full_rejects++;
                if (outcome_queue.size() == 0) begin
                    flag_failure("result word with no command outstanding", '0, i_result_word);
                end else begin
                    want = outcome_queue.pop_front();
                    if (i_result_word.success !== want.success ||
                        i_result_word.full_reject !== want.full_reject ||
                        i_result_word.count !== want.count)
                        flag_failure("result word mismatch", want, i_result_word);
                end
            end
            if (i_start && !i_busy)
                outcome_queue.push_back(apply_set_op(i_cmd_word));
        end
        o_pending = outcome_queue.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import alls_pkg::*;

    localparam logic [CMD_W-1:0] CMD_IDLE = 2'd3;
    localparam int RANDOM_WORDS = 1050;
    localparam int CYCLE_LIMIT  = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_word;
    logic      o_strobe;
    t_out_word o_word;

    int fail_count;
    int pending;
    int results;
    int full_rejects;
    int cycles = 0;
    int cmd_tally [4];

    logic [VAL_W-1:0] value_pool [24];

    always #10 i_clk = ~i_clk;

    array_linked_list_set_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    alls_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd_word     (i_word),
        .i_strobe       (o_strobe),
        .i_result_word  (o_word),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results      (results),
        .o_full_rejects (full_rejects)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("array_linked_list_set_top verification failed");
            $finish;
        end
    end

    // drive one command word, hold it until taken, then idle for gap cycles
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                         input int gap);
        @(negedge i_clk);
        start  <= 1'b1;
        i_word <= '{command: cmd, value: val};
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        cmd_tally[cmd]++;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    initial begin
        int                r;
        int                gap;
        logic [CMD_W-1:0]  cmd;
        logic [VAL_W-1:0]  val;
        logic              add_heavy;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_word  = '0;
        for (int i = 0; i < 4; i++) cmd_tally[i] = 0;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h7FFF_FFFF;
        value_pool[3] = 32'h8000_0000;
        for (int i = 4; i < 24; i++) value_pool[i] = $urandom;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty set, extremes, duplicates, unlink of middle and tail, full set
        issue(CMD_SEARCH, 32'h0000_0000, 0);
        issue(CMD_REMOVE, 32'h0000_0000, 0);
        issue(CMD_IDLE,   32'hFFFF_FFFF, 0);
        issue(CMD_ADD,    32'h7FFF_FFFF, 0);
        issue(CMD_ADD,    32'h8000_0000, 0);
        issue(CMD_ADD,    32'h0000_0000, 0);
        issue(CMD_ADD,    32'hFFFF_FFFF, 0);
        issue(CMD_ADD,    32'h7FFF_FFFF, 0);
        issue(CMD_SEARCH, 32'h8000_0000, 0);
        issue(CMD_SEARCH, 32'h0000_3039, 0);
        issue(CMD_REMOVE, 32'h8000_0000, 0);
        issue(CMD_REMOVE, 32'hFFFF_FFFF, 0);
        for (int i = 1; i <= CAPACITY - 2; i++)
            issue(CMD_ADD, i * 32'h0101_0101, 0);
        issue(CMD_ADD,    32'h5555_AAAA, 0);
        issue(CMD_ADD,    32'h0000_0000, 0);
        issue(CMD_SEARCH, 32'h0E0E_0E0E, 0);

        // random: phases alternate between filling and draining the set
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            add_heavy = ((k / 150) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < (add_heavy ? 50 : 20))      cmd = CMD_ADD;
            else if (r < (add_heavy ? 70 : 60)) cmd = CMD_REMOVE;
            else if (r < 95)                    cmd = CMD_SEARCH;
            else                                cmd = CMD_IDLE;
            if ($urandom_range(0, 99) < 80) val = value_pool[$urandom_range(0, 23)];
            else val = $urandom;
            r = $urandom_range(0, 99);
            if (k % 150 < 40) gap = 0;
            else if (r < 50)  gap = 0;
            else if (r < 90)  gap = $urandom_range(1, 3);
            else              gap = $urandom_range(10, 40);
            issue(cmd, val, gap);
        end

        @(negedge i_clk);
        start <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge i_clk);

        $display("issued %0d command words: %0d add, %0d remove, %0d search, %0d no-op",
                 cmd_tally[CMD_ADD] + cmd_tally[CMD_REMOVE] + cmd_tally[CMD_SEARCH]
                 + cmd_tally[CMD_IDLE], cmd_tally[CMD_ADD], cmd_tally[CMD_REMOVE],
                 cmd_tally[CMD_SEARCH], cmd_tally[CMD_IDLE]);
        $display("checked %0d result words, %0d of them adds rejected on a full set",
                 results, full_rejects);
        if (fail_count == 0 && pending == 0) begin
            $display("array_linked_list_set_top verification clean");
        end else begin
            $display("%0d mismatches, %0d results never seen", fail_count, pending);
            $display("array_linked_list_set_top verification failed");
        end
        $finish;
    end

endmodule
